>>> hw/rtl/lattice_neighbour_index_macros.svh
// Assertion macros for the lattice neighbour index RTL.
`ifndef LATTICE_NEIGHBOUR_INDEX_MACROS_SVH
`define LATTICE_NEIGHBOUR_INDEX_MACROS_SVH
`ifndef SYNTHESIS
`define LNI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LNI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LNI_ASSERT(label, clk, rst_n, prop, msg)
`define LNI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/lni_pkg.sv
package lni_pkg;

  localparam int unsigned IdxW   = 24;
  localparam int unsigned DirW   = 3;
  localparam int unsigned CoordW = 8;
  localparam int unsigned SideW  = 9;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 4;

  // Sides above this saturate; the datapath widths are sized for it.
  localparam int unsigned MaxSide = 256;

  localparam logic [AddrW-1:0] RegSideX = 4'h0;
  localparam logic [AddrW-1:0] RegSideY = 4'h4;
  localparam logic [AddrW-1:0] RegSideZ = 4'h8;

  typedef enum logic [DirW-1:0] {
    DirXDn = 3'd0,
    DirXUp = 3'd1,
    DirYDn = 3'd2,
    DirYUp = 3'd3,
    DirZDn = 3'd4,
    DirZUp = 3'd5
  } dir_e;

  typedef struct packed {
    logic [IdxW-1:0]   site_index;
    logic [DirW-1:0]   direction;
    logic              wrap;
  } req_t;

  typedef struct packed {
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [CoordW-1:0] coord_z;
    logic              site_ok;
    logic [IdxW-1:0]   neighbour_index;
    logic              neighbour_ok;
  } rsp_t;

endpackage

>>> hw/rtl/lni_stream_if.sv
interface lni_stream_if #(
  parameter type PayloadT = logic
);
  logic    valid;
  logic    ready;
  PayloadT data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/lni_divstage.sv
// One restoring-division step per stage for a quotient bit, carried with the
// whole item context. Stages are chained by the top level.
module lni_divstage #(
  parameter int unsigned NumW = 24,
  parameter int unsigned DenW = 17,
  parameter int unsigned CtxW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] rem_i,
  input  logic [NumW-1:0] quo_i,
  input  logic [DenW-1:0] den_i,
  input  logic [4:0]      shift_i,
  input  logic [CtxW-1:0] ctx_i,
  output logic            valid_o,
  output logic [NumW-1:0] rem_o,
  output logic [NumW-1:0] quo_o,
  output logic [CtxW-1:0] ctx_o
);
  logic [NumW+DenW-1:0] den_sh;
  logic                 fits;
  logic [NumW-1:0]      rem_d, quo_d;

  always_comb begin
    den_sh = {{NumW{1'b0}}, den_i} << shift_i;
    fits   = {{DenW{1'b0}}, rem_i} >= den_sh;
    rem_d  = fits ? rem_i - den_sh[NumW-1:0] : rem_i;
    quo_d  = quo_i | (NumW'(fits) << shift_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      quo_o <= quo_d;
      ctx_o <= ctx_i;
    end
  end
endmodule

>>> hw/rtl/lni_regs.sv
module lni_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lni_pkg::AddrW-1:0]      paddr,
  input  logic [lni_pkg::DataW-1:0]      pwdata,
  output logic [lni_pkg::DataW-1:0]      prdata,
  output logic                           pready,
  output logic [lni_pkg::SideW-1:0]      nx_o,
  output logic [lni_pkg::SideW-1:0]      ny_o,
  output logic [lni_pkg::SideW-1:0]      nz_o
);
  logic [lni_pkg::SideW-1:0] sx_q, sy_q, sz_q;
  logic                      wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= lni_pkg::SideW'(1);
      sy_q <= lni_pkg::SideW'(1);
      sz_q <= lni_pkg::SideW'(1);
    end else if (wr) begin
      unique case (paddr)
        lni_pkg::RegSideX: sx_q <= pwdata[lni_pkg::SideW-1:0];
        lni_pkg::RegSideY: sy_q <= pwdata[lni_pkg::SideW-1:0];
        lni_pkg::RegSideZ: sz_q <= pwdata[lni_pkg::SideW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      lni_pkg::RegSideX: prdata = lni_pkg::DataW'(sx_q);
      lni_pkg::RegSideY: prdata = lni_pkg::DataW'(sy_q);
      lni_pkg::RegSideZ: prdata = lni_pkg::DataW'(sz_q);
      default:           prdata = '0;
    endcase
  end

  // Sides above the maximum saturate.
  function automatic logic [lni_pkg::SideW-1:0] sat(input logic [lni_pkg::SideW-1:0] v);
    return (32'(v) > lni_pkg::MaxSide) ? lni_pkg::SideW'(lni_pkg::MaxSide) : v;
  endfunction

  assign nx_o = sat(sx_q);
  assign ny_o = sat(sy_q);
  assign nz_o = sat(sz_q);
endmodule

>>> hw/rtl/lattice_neighbour_index.sv
// Lattice neighbour index: splits a linear site index into x, y, z using the
// configured side lengths, steps one site and packs the neighbour back. One
// transaction per cycle is taken while the output is not stalled; the pipeline
// has 43 register stages: one product stage, 24 restoring-division steps for
// the x coordinate, 16 for y, a step stage and a pack multiply stage that ends
// in the output register. Sides saturate at 256 and are read live from the
// registers, so they must be written only while the pipeline is empty; the
// block does not enforce this. Stalls freeze the whole pipeline.
module lattice_neighbour_index (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lni_stream_if.sink                        in_if,
  lni_stream_if.source                      out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lni_pkg::AddrW-1:0]         paddr,
  input  logic [lni_pkg::DataW-1:0]         pwdata,
  output logic [lni_pkg::DataW-1:0]         prdata,
  output logic                              pready
);
  `include "lattice_neighbour_index_macros.svh"

  localparam int unsigned IdxW  = lni_pkg::IdxW;
  localparam int unsigned SideW = lni_pkg::SideW;
  localparam int unsigned PlW   = 2 * SideW;
  localparam int unsigned YSteps = PlW - 2;
  localparam int unsigned CtxW  = lni_pkg::DirW + 2;

  logic [SideW-1:0] nx, ny, nz;
  logic             en;

  lni_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .nx_o(nx), .ny_o(ny), .nz_o(nz)
  );

  assign en          = out_if.ready || !out_if.valid;
  assign in_if.ready = en;

  // Stage 0: plane size, lattice size, range check.
  logic [PlW-1:0]     plane;
  logic [IdxW+8:0]    total;
  logic               v0_q, ok0_q;
  logic [IdxW-1:0]    idx0_q;
  logic [CtxW-1:0]    ctx0_q;
  logic [PlW-1:0]     pl_q;

  assign plane = ny * nz;
  assign total = (IdxW+9)'(nx) * (IdxW+9)'(pl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_if.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      idx0_q <= in_if.data.site_index;
      ctx0_q <= {in_if.data.direction, in_if.data.wrap, 1'b0};
      pl_q   <= plane;
    end
  end
  assign ok0_q = (total != '0) && ((IdxW+9)'(idx0_q) < total);

  // x = idx / plane over IdxW steps, MSB first.
  logic            xv  [IdxW+1];
  logic [IdxW-1:0] xr  [IdxW+1];
  logic [IdxW-1:0] xqq [IdxW+1];
  logic [CtxW-1:0] xc  [IdxW+1];
  assign xv[0]  = v0_q;
  assign xr[0]  = ok0_q ? idx0_q : '0;
  assign xqq[0] = '0;
  assign xc[0]  = {ctx0_q[CtxW-1:1], ok0_q};

  for (genvar g = 0; g < IdxW; g++) begin : g_xdiv
    lni_divstage #(.NumW(IdxW), .DenW(PlW), .CtxW(CtxW)) u_st (
      .clk_i, .rst_ni, .en_i(en), .valid_i(xv[g]), .rem_i(xr[g]), .quo_i(xqq[g]),
      .den_i(pl_q), .shift_i(5'(IdxW-1-g)), .ctx_i(xc[g]),
      .valid_o(xv[g+1]), .rem_o(xr[g+1]), .quo_o(xqq[g+1]), .ctx_o(xc[g+1])
    );
  end

  // y = rem / nz; remainder is below 2^16 so YSteps bits suffice.
  logic            yv  [YSteps+1];
  logic [IdxW-1:0] yr  [YSteps+1];
  logic [IdxW-1:0] yq  [YSteps+1];
  logic [CtxW+7:0] yc  [YSteps+1];
  assign yv[0] = xv[IdxW];
  assign yr[0] = xr[IdxW];
  assign yq[0] = '0;
  assign yc[0] = {xqq[IdxW][7:0], xc[IdxW]};

  for (genvar g = 0; g < YSteps; g++) begin : g_ydiv
    lni_divstage #(.NumW(IdxW), .DenW(SideW), .CtxW(CtxW+8)) u_st (
      .clk_i, .rst_ni, .en_i(en), .valid_i(yv[g]), .rem_i(yr[g]), .quo_i(yq[g]),
      .den_i(nz), .shift_i(5'(YSteps-1-g)), .ctx_i(yc[g]),
      .valid_o(yv[g+1]), .rem_o(yr[g+1]), .quo_o(yq[g+1]), .ctx_o(yc[g+1])
    );
  end

  // Step stage.
  logic [SideW-1:0] cx, cy, cz, sx, sy, sz, n_ax, c_ax, s_ax;
  logic             ok_s, wrap_s, up, nb_ok;
  logic [lni_pkg::DirW-1:0] dir_s;

  assign cx     = {1'b0, yc[YSteps][CtxW+7:CtxW]};
  assign cy     = yq[YSteps][SideW-1:0];
  assign cz     = yr[YSteps][SideW-1:0];
  assign ok_s   = yc[YSteps][0];
  assign wrap_s = yc[YSteps][1];
  assign dir_s  = yc[YSteps][CtxW-1:2];
  assign up     = dir_s[0];

  always_comb begin
    sx = cx; sy = cy; sz = cz;
    unique case (dir_s)
      lni_pkg::DirXDn, lni_pkg::DirXUp: begin c_ax = cx; n_ax = nx; end
      lni_pkg::DirYDn, lni_pkg::DirYUp: begin c_ax = cy; n_ax = ny; end
      default:                          begin c_ax = cz; n_ax = nz; end
    endcase
    nb_ok = ok_s && (dir_s <= lni_pkg::DirW'(lni_pkg::DirZUp));
    if (up) begin
      if (c_ax + SideW'(1) < n_ax) s_ax = c_ax + SideW'(1);
      else begin s_ax = '0; nb_ok = nb_ok && wrap_s; end
    end else begin
      if (c_ax != '0) s_ax = c_ax - SideW'(1);
      else begin s_ax = n_ax - SideW'(1); nb_ok = nb_ok && wrap_s; end
    end
    unique case (dir_s)
      lni_pkg::DirXDn, lni_pkg::DirXUp: sx = s_ax;
      lni_pkg::DirYDn, lni_pkg::DirYUp: sy = s_ax;
      default:                          sz = s_ax;
    endcase
  end

  logic             v1_q, ok1_q, nbok1_q;
  logic [SideW-1:0] cx1_q, cy1_q, cz1_q, sx1_q, sz1_q;
  logic [PlW-1:0]   syz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= yv[YSteps];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok1_q   <= ok_s;
      nbok1_q <= nb_ok;
      cx1_q   <= ok_s ? cx : '0;
      cy1_q   <= ok_s ? cy : '0;
      cz1_q   <= ok_s ? cz : '0;
      sx1_q   <= sx;
      sz1_q   <= sz;
      syz1_q  <= sy * nz;
    end
  end

  // Pack stage into the output register.
  logic [IdxW+8:0] nb;
  lni_pkg::rsp_t   rsp_q;
  logic            ov_q;

  assign nb = (IdxW+9)'(sx1_q) * (IdxW+9)'(pl_q) + (IdxW+9)'(syz1_q) + (IdxW+9)'(sz1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_q.coord_x         <= cx1_q[7:0];
      rsp_q.coord_y         <= cy1_q[7:0];
      rsp_q.coord_z         <= cz1_q[7:0];
      rsp_q.site_ok         <= ok1_q;
      rsp_q.neighbour_ok    <= nbok1_q;
      rsp_q.neighbour_index <= nbok1_q ? nb[IdxW-1:0] : '0;
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.data  = rsp_q;

  `LNI_ASSERT_IMPL(a_nb_needs_site, clk_i, rst_ni, out_if.valid && out_if.data.neighbour_ok,
    out_if.data.site_ok, "neighbour valid without valid site")
  `LNI_ASSERT_IMPL(a_bad_nb_zero, clk_i, rst_ni, out_if.valid && !out_if.data.neighbour_ok,
    out_if.data.neighbour_index == '0, "invalid neighbour index not zero")
  `LNI_ASSERT_IMPL(a_stall_hold, clk_i, rst_ni, $past(out_if.valid && !out_if.ready),
    out_if.valid && $stable(out_if.data), "stalled result changed")
endmodule

>>> tb/sv/lni_checker.sv
`timescale 1ns / 1ps

module lni_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  lni_pkg::req_t           in_data_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  lni_pkg::rsp_t           out_data_i,
  input  logic [lni_pkg::SideW-1:0] side_x_i,
  input  logic [lni_pkg::SideW-1:0] side_y_i,
  input  logic [lni_pkg::SideW-1:0] side_z_i,
  output int                      pending_o,
  output int                      errors_o
);
  lni_pkg::rsp_t neighbour_q[$];

  function automatic longint unsigned clamp_side(logic [lni_pkg::SideW-1:0] v);
    return (v > lni_pkg::MaxSide) ? lni_pkg::MaxSide : longint'(v);
  endfunction

  function automatic lni_pkg::rsp_t lookup_neighbour(lni_pkg::req_t req);
    lni_pkg::rsp_t r;
    longint unsigned nx, ny, nz, plane, total, idx;
    longint unsigned x, y, z, sx, sy, sz, c, n;
    logic ok, up;
    r = '0;
    nx = clamp_side(side_x_i);
    ny = clamp_side(side_y_i);
    nz = clamp_side(side_z_i);
    plane = ny * nz;
    total = nx * plane;
    idx = req.site_index;
    if (total != 0 && idx < total) begin
      x = idx / plane;
      y = (idx % plane) / nz;
      z = idx % nz;
      r.coord_x = x[7:0];
      r.coord_y = y[7:0];
      r.coord_z = z[7:0];
      r.site_ok = 1'b1;
      sx = x;
      sy = y;
      sz = z;
      up = req.direction[0];
      ok = 1'b1;
      case (req.direction)
        lni_pkg::DirXDn, lni_pkg::DirXUp: begin c = x; n = nx; end
        lni_pkg::DirYDn, lni_pkg::DirYUp: begin c = y; n = ny; end
        lni_pkg::DirZDn, lni_pkg::DirZUp: begin c = z; n = nz; end
        default: ok = 1'b0;
      endcase
      if (ok) begin
        if (up) begin
          if (c + 1 < n) c = c + 1;
          else if (req.wrap) c = 0;
          else ok = 1'b0;
        end else begin
          if (c > 0) c = c - 1;
          else if (req.wrap) c = n - 1;
          else ok = 1'b0;
        end
      end
      if (ok) begin
        case (req.direction)
          lni_pkg::DirXDn, lni_pkg::DirXUp: sx = c;
          lni_pkg::DirYDn, lni_pkg::DirYUp: sy = c;
          default: sz = c;
        endcase
        r.neighbour_index = lni_pkg::IdxW'(sx * plane + sy * nz + sz);
        r.neighbour_ok = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lni_pkg::rsp_t want;
    if (!rst_ni) begin
      neighbour_q.delete();
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) neighbour_q.push_back(lookup_neighbour(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (neighbour_q.size() == 0) begin
          $error("unexpected result transaction");
          errors_o <= errors_o + 1;
        end else begin
          want = neighbour_q.pop_front();
          if (want !== out_data_i) begin
            errors_o <= errors_o + 1;
            if (want.coord_x !== out_data_i.coord_x)
              $error("coord_x: expected %0d, got %0d", want.coord_x, out_data_i.coord_x);
            if (want.coord_y !== out_data_i.coord_y)
              $error("coord_y: expected %0d, got %0d", want.coord_y, out_data_i.coord_y);
            if (want.coord_z !== out_data_i.coord_z)
              $error("coord_z: expected %0d, got %0d", want.coord_z, out_data_i.coord_z);
            if (want.site_ok !== out_data_i.site_ok)
              $error("site_ok: expected %0d, got %0d", want.site_ok, out_data_i.site_ok);
            if (want.neighbour_index !== out_data_i.neighbour_index)
              $error("neighbour_index: expected %0d, got %0d", want.neighbour_index,
                     out_data_i.neighbour_index);
            if (want.neighbour_ok !== out_data_i.neighbour_ok)
              $error("neighbour_ok: expected %0d, got %0d", want.neighbour_ok,
                     out_data_i.neighbour_ok);
          end
        end
      end
    end
  end

  assign pending_o = neighbour_q.size();
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [lni_pkg::AddrW-1:0] paddr;
  logic [lni_pkg::DataW-1:0] pwdata, prdata;
  logic [lni_pkg::SideW-1:0] side_x, side_y, side_z;
  int pending, errors, send_idle, sink_stall;

  lni_stream_if #(.PayloadT(lni_pkg::req_t)) in_if ();
  lni_stream_if #(.PayloadT(lni_pkg::rsp_t)) out_if ();

  lattice_neighbour_index dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lni_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_i(in_if.ready), .in_data_i(in_if.data),
    .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data),
    .side_x_i(side_x), .side_y_i(side_y), .side_z_i(side_z),
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("testbench failed");
    $finish;
  end

  // The receiver stalls at a rate set by the current phase.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_stall);
  end

  task automatic write_side(logic [lni_pkg::AddrW-1:0] addr, logic [lni_pkg::DataW-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      lni_pkg::RegSideX: side_x = value[lni_pkg::SideW-1:0];
      lni_pkg::RegSideY: side_y = value[lni_pkg::SideW-1:0];
      default:           side_z = value[lni_pkg::SideW-1:0];
    endcase
  endtask

  task automatic drain_pipeline();
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_lattice(int unsigned sx, int unsigned sy, int unsigned sz);
    drain_pipeline();
    write_side(lni_pkg::RegSideX, sx);
    write_side(lni_pkg::RegSideY, sy);
    write_side(lni_pkg::RegSideZ, sz);
  endtask

  // Valid stays high after acceptance; the next caller either drives a new
  // transaction or drops it.
  task automatic send_step(logic [lni_pkg::IdxW-1:0] idx, logic [lni_pkg::DirW-1:0] dir,
                           logic wrap);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{site_index: idx, direction: dir, wrap: wrap};
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Mostly indices inside the lattice, some just past its end, a few anywhere.
  task automatic random_steps(int count);
    longint unsigned total;
    logic [lni_pkg::IdxW-1:0] idx;
    for (int i = 0; i < count; i++) begin
      total = (side_x > 256 ? 256 : side_x) * (side_y > 256 ? 256 : side_y) *
              (side_z > 256 ? 256 : side_z);
      case ($urandom_range(9))
        0: idx = lni_pkg::IdxW'($urandom);
        1: idx = (total < 16777216) ? lni_pkg::IdxW'(total + $urandom_range(3)) :
                 lni_pkg::IdxW'($urandom);
        default: idx = (total == 0) ? lni_pkg::IdxW'($urandom) :
                       lni_pkg::IdxW'($urandom % total);
      endcase
      send_step(idx, lni_pkg::DirW'($urandom_range(7)), 1'($urandom_range(1)));
    end
  endtask

  task automatic set_phase(int phase);
    case (phase % 4)
      0: begin send_idle = 0;  sink_stall = 0;  end
      1: begin send_idle = 63; sink_stall = 0;  end
      2: begin send_idle = 0;  sink_stall = 63; end
      default: begin send_idle = 14; sink_stall = 14; end
    endcase
  endtask

  initial begin
    int sides[12][3];
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    side_x = 1;
    side_y = 1;
    side_z = 1;
    send_idle = 0;
    sink_stall = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset lattice of one site, then a 256 cube and odd shapes.
    for (int d = 0; d < 8; d++) send_step(lni_pkg::IdxW'(0), lni_pkg::DirW'(d), d[0]);
    send_step(lni_pkg::IdxW'(1), lni_pkg::DirXUp, 1'b1);
    set_lattice(256, 256, 256);
    send_step(lni_pkg::IdxW'(0), lni_pkg::DirXDn, 1'b0);
    send_step(lni_pkg::IdxW'(0), lni_pkg::DirYDn, 1'b1);
    send_step(24'hFFFFFF, lni_pkg::DirZUp, 1'b1);
    send_step(24'hFFFFFF, lni_pkg::DirXUp, 1'b0);
    send_step(24'h123456, lni_pkg::DirYUp, 1'b0);
    set_lattice(3, 5, 7);
    send_step(lni_pkg::IdxW'(104), lni_pkg::DirZUp, 1'b1);
    send_step(lni_pkg::IdxW'(104), lni_pkg::DirZUp, 1'b0);
    send_step(lni_pkg::IdxW'(105), lni_pkg::DirXDn, 1'b0);
    send_step(lni_pkg::IdxW'(0), lni_pkg::DirYDn, 1'b1);
    set_lattice(511, 0, 300);
    send_step(lni_pkg::IdxW'(5), lni_pkg::DirXUp, 1'b1);
    send_step(lni_pkg::IdxW'(0), lni_pkg::DirZDn, 1'b1);

    sides = '{'{1, 1, 1}, '{256, 256, 256}, '{2, 3, 4}, '{256, 1, 256},
              '{5, 7, 9}, '{1, 256, 1}, '{0, 4, 4}, '{300, 2, 511},
              '{16, 16, 16}, '{7, 1, 13}, '{100, 200, 50}, '{3, 3, 2}};
    for (int p = 0; p < 12; p++) begin
      set_phase(p);
      set_lattice(sides[p][0], sides[p][1], sides[p][2]);
      random_steps(60);
      if (p == 5) begin
        // Hold the sender until the pipeline has drained completely.
        in_if.valid <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
      random_steps(60);
    end

    in_if.valid <= 1'b0;
    for (int w = 0; w < 2000 && pending != 0; w++) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
